@@ hdl/sps_pkg.sv @@
package sps_pkg;

  localparam int CAPACITY    = 1024;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;
  localparam int PAYLOAD_W   = 32;
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_SWEEP = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic load;
    logic sweep_start;
    logic commit;
    logic sweep_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/sps_ctrl.sv @@
module sps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  sps_pkg::func_t      in_func,
  output logic                in_ready,
  output sps_pkg::cmd_t       cmd,
  input  sps_pkg::stat_t      stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMMIT,
    S_SWEEP,
    S_SWEEP_END
  } state_t;

  state_t state;

  always_comb begin
    in_ready        = (state == S_IDLE);
    cmd.load        = in_ready && in_valid;
    cmd.sweep_start = cmd.load && (in_func == sps_pkg::FUNC_SWEEP);
    cmd.commit      = (state == S_COMMIT) && stat.out_free;
    cmd.sweep_run   = (state == S_SWEEP);
    cmd.finish      = (state == S_SWEEP_END) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= (in_func == sps_pkg::FUNC_SWEEP) ? S_SWEEP : S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        S_SWEEP: begin
          if (stat.sweep_done) state <= S_SWEEP_END;
        end
        S_SWEEP_END: begin
          if (stat.out_free) state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/sps_dp.sv @@
module sps_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  sps_pkg::cmd_t                   cmd,
  output sps_pkg::stat_t                  stat,
  input  sps_pkg::func_t                  in_func,
  input  logic [sps_pkg::SLOT_W-1:0]      in_slot,
  input  logic [sps_pkg::DATA_W-1:0]      in_payload,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [sps_pkg::SLOT_W-1:0]      slot_out,
  output logic [sps_pkg::DATA_W-1:0]      payload_out,
  output logic [sps_pkg::CNT_W-1:0]       live_count,
  output logic [sps_pkg::CNT_W-1:0]       freed_count,
  output logic [sps_pkg::STATUS_W-1:0]    status
);

  localparam logic [1:0] FLAGS_FREE = 2'b00;
  localparam logic [1:0] FLAGS_LIVE = 2'b01;
  localparam logic [1:0] FLAGS_KEPT = 2'b11;

  logic [sps_pkg::PAYLOAD_W-1:0] pay_mem  [sps_pkg::CAPACITY];
  logic [sps_pkg::CNT_W-1:0]     link_mem [sps_pkg::CAPACITY];
  logic [1:0]                    flag_mem [sps_pkg::CAPACITY];

  logic [sps_pkg::PAYLOAD_W-1:0] pay_rd;
  logic [sps_pkg::CNT_W-1:0]     link_rd;
  logic [1:0]                    flag_rd;

  sps_pkg::func_t                func_q;
  logic [sps_pkg::SLOT_W-1:0]    slot_q;
  logic [sps_pkg::PAYLOAD_W-1:0] pay_q;

  logic [sps_pkg::CNT_W-1:0]     hw;
  logic [sps_pkg::CNT_W-1:0]     free_head;
  logic [sps_pkg::CNT_W-1:0]     live_total;
  logic [sps_pkg::CNT_W-1:0]     freed;
  logic [sps_pkg::CNT_W-1:0]     idx;
  logic                          p_valid;
  logic [sps_pkg::SLOT_W-1:0]    p_idx;

  logic                          pop;
  logic                          full;
  logic                          ok;
  logic                          scan_more;
  logic                          p_free;
  logic                          p_keep;
  logic [sps_pkg::SLOT_W-1:0]    alloc_slot;
  logic [sps_pkg::SLOT_W-1:0]    rd_addr;

  logic                          pay_we;
  logic                          link_we;
  logic                          flag_we;
  logic [sps_pkg::SLOT_W-1:0]    flag_wa;
  logic [1:0]                    flag_wd;

  logic [sps_pkg::SLOT_W-1:0]    o_slot;
  logic [sps_pkg::DATA_W-1:0]    o_pay;
  logic [sps_pkg::CNT_W-1:0]     o_live;
  logic [sps_pkg::CNT_W-1:0]     o_freed;
  logic [sps_pkg::STATUS_W-1:0]  o_status;

  // Entries at or above the high-water mark were never written and count as free.
  always_comb begin
    pop        = (free_head != hw) && (free_head < sps_pkg::CNT_W'(sps_pkg::CAPACITY));
    full       = !pop && (hw >= sps_pkg::CNT_W'(sps_pkg::CAPACITY));
    ok         = ({1'b0, slot_q} < hw) && flag_rd[0];
    alloc_slot = pop ? free_head[sps_pkg::SLOT_W-1:0] : hw[sps_pkg::SLOT_W-1:0];
    scan_more  = idx < hw;
    p_free     = p_valid && (flag_rd == FLAGS_LIVE);
    p_keep     = p_valid && (flag_rd == FLAGS_KEPT);

    stat.sweep_done = !scan_more && !p_valid;
    stat.out_free   = !out_valid || out_ready;

    if (cmd.load) begin
      rd_addr = (in_func == sps_pkg::FUNC_ALLOC) ? free_head[sps_pkg::SLOT_W-1:0] : in_slot;
    end else if (cmd.sweep_run) begin
      rd_addr = idx[sps_pkg::SLOT_W-1:0];
    end else begin
      rd_addr = (func_q == sps_pkg::FUNC_ALLOC) ? free_head[sps_pkg::SLOT_W-1:0] : slot_q;
    end

    pay_we  = 1'b0;
    link_we = 1'b0;
    flag_we = 1'b0;
    flag_wa = alloc_slot;
    flag_wd = FLAGS_LIVE;
    if (cmd.commit) begin
      if (func_q == sps_pkg::FUNC_ALLOC && !full) begin
        pay_we  = 1'b1;
        flag_we = 1'b1;
      end else if (func_q == sps_pkg::FUNC_MARK && ok) begin
        flag_we = 1'b1;
        flag_wa = slot_q;
        flag_wd = FLAGS_KEPT;
      end
    end
    if (cmd.sweep_run) begin
      if (p_free) begin
        flag_we = 1'b1;
        link_we = 1'b1;
        flag_wa = p_idx;
        flag_wd = FLAGS_FREE;
      end else if (p_keep) begin
        flag_we = 1'b1;
        flag_wa = p_idx;
        flag_wd = FLAGS_LIVE;
      end
    end

    o_slot   = slot_q;
    o_pay    = '0;
    o_live   = live_total;
    o_freed  = '0;
    o_status = ok ? sps_pkg::STAT_OK : sps_pkg::STAT_BAD;
    if (cmd.finish) begin
      o_slot   = '0;
      o_freed  = freed;
      o_status = sps_pkg::STAT_OK;
    end else if (func_q == sps_pkg::FUNC_ALLOC) begin
      if (full) begin
        o_slot   = '0;
        o_status = sps_pkg::STAT_FULL;
      end else begin
        o_slot   = alloc_slot;
        o_live   = live_total + 1'b1;
        o_status = sps_pkg::STAT_OK;
      end
    end else if (func_q == sps_pkg::FUNC_READ && ok) begin
      o_pay = sps_pkg::DATA_W'(pay_rd);
    end
  end

  always_ff @(posedge clk) begin
    pay_rd <= pay_mem[rd_addr];
    if (pay_we) pay_mem[alloc_slot] <= pay_q;
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[rd_addr];
    if (link_we) link_mem[p_idx] <= free_head;
  end

  always_ff @(posedge clk) begin
    flag_rd <= flag_mem[rd_addr];
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      slot_q <= in_slot;
      pay_q  <= sps_pkg::PAYLOAD_W'(in_payload);
    end
    if (cmd.sweep_run && scan_more) p_idx <= idx[sps_pkg::SLOT_W-1:0];
    if (cmd.commit || cmd.finish) begin
      slot_out    <= o_slot;
      payload_out <= o_pay;
      live_count  <= o_live;
      freed_count <= o_freed;
      status      <= o_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hw         <= '0;
      free_head  <= '0;
      live_total <= '0;
      freed      <= '0;
      idx        <= '0;
      p_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit || cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cmd.commit && func_q == sps_pkg::FUNC_ALLOC && !full) begin
        live_total <= live_total + 1'b1;
        if (pop) begin
          free_head <= link_rd;
        end else begin
          hw        <= hw + 1'b1;
          free_head <= hw + 1'b1;
        end
      end

      if (cmd.sweep_start) begin
        idx     <= '0;
        freed   <= '0;
        p_valid <= 1'b0;
      end

      if (cmd.sweep_run) begin
        p_valid <= scan_more;
        if (scan_more) idx <= idx + 1'b1;
        if (p_free) begin
          free_head  <= {1'b0, p_idx};
          live_total <= live_total - 1'b1;
          freed      <= freed + 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/slot_pool_mark_sweep.sv @@
// Allocate, mark and read: the beat is accepted in the idle state, then the result is
// registered in the commit state, which waits while the output is held; a new beat is taken only after that.
// A sweep makes one flag memory read per slot below the high-water mark, then registers
// its result in the sweep-end state, which also waits while the output is held.
// Reset is synchronous and clears the counters, high-water mark and control state.
// The memories are not cleared; the high-water mark screens slots never written.
module slot_pool_mark_sweep (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sps_pkg::IN_TDATA_W-1:0]     s_tdata,   // slot, payload, zero fill
  input  logic [sps_pkg::FUNC_W-1:0]         s_tuser,   // func
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sps_pkg::OUT_TDATA_W-1:0]    m_tdata,   // slot_out, payload_out,
                                                        // live_count, freed_count
  output logic [sps_pkg::STATUS_W-1:0]       m_tuser    // status
);

  sps_pkg::cmd_t                   cmd;
  sps_pkg::stat_t                  stat;
  sps_pkg::func_t                  in_func;
  logic [sps_pkg::SLOT_W-1:0]      slot_out;
  logic [sps_pkg::DATA_W-1:0]      payload_out;
  logic [sps_pkg::CNT_W-1:0]       live_count;
  logic [sps_pkg::CNT_W-1:0]       freed_count;

  assign in_func = sps_pkg::func_t'(s_tuser);
  assign m_tdata = {freed_count, live_count, payload_out, slot_out};

  sps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (in_func),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_func),
    .in_slot     (s_tdata[sps_pkg::SLOT_W-1:0]),
    .in_payload  (s_tdata[sps_pkg::SLOT_W +: sps_pkg::DATA_W]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .slot_out    (slot_out),
    .payload_out (payload_out),
    .live_count  (live_count),
    .freed_count (freed_count),
    .status      (m_tuser)
  );

endmodule
